/* hw/rtl/dpb_pkg.sv */
// Shared widths, register indexes and interface types for the depth back-projection block.
package dpb_pkg;

  localparam int COORD_W = 12;
  localparam int DEPTH_W = 16;
  localparam int CONF_W  = 8;
  localparam int CFG_W   = 16;
  localparam int DIM_W   = 13;
  localparam int IDX_W   = 3;
  localparam int OUT_W   = 24;
  localparam int DIFF_W  = 17;
  localparam int MAG_W   = 16;
  localparam int NUM_W   = 32;

  localparam int SUBSAMPLE_STEP_DEF = 4;
  localparam int MAX_DIMENSION_DEF  = 4096;

  localparam logic [DEPTH_W-1:0] DEPTH_LIMIT = 16'd40960;
  localparam logic [OUT_W-1:0]   OUT_POS_MAX = 24'h7fffff;
  localparam logic [OUT_W-1:0]   OUT_NEG_MIN = 24'h800000;

  // register indexes on the configuration port
  localparam logic [IDX_W-1:0] REG_FOCAL_X      = 3'd0;
  localparam logic [IDX_W-1:0] REG_FOCAL_Y      = 3'd1;
  localparam logic [IDX_W-1:0] REG_CENTER_X     = 3'd2;
  localparam logic [IDX_W-1:0] REG_CENTER_Y     = 3'd3;
  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd4;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd5;

  localparam logic [CFG_W-1:0] FOCAL_X_RST      = 16'd8000;
  localparam logic [CFG_W-1:0] FOCAL_Y_RST      = 16'd8000;
  localparam logic [CFG_W-1:0] CENTER_X_RST     = 16'd2048;
  localparam logic [CFG_W-1:0] CENTER_Y_RST     = 16'd1536;
  localparam logic [DIM_W-1:0] IMAGE_WIDTH_RST  = 13'd256;
  localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RST = 13'd192;

  // signed numerator as sign and magnitude
  typedef struct packed {
    logic             neg;
    logic [NUM_W-1:0] mag;
  } axis_t;

  typedef struct packed {
    logic               valid;
    logic [DEPTH_W-1:0] depth;
    logic [CONF_W-1:0]  conf;
  } side_t;

endpackage

/* hw/rtl/depth_pixel_backprojection_top.sv */
// Depth pixel back-projection: a pinhole camera model turning depth pixels into camera points.
//
// One depth pixel can be taken every clock. A pixel that lies on the subsample grid, inside
// the configured image and has a depth in (0, 10 m] yields one point after the filter and
// multiply stages, 32 stages of the bit-per-stage divider giving (16*pos - c) * d / f for x
// and y in parallel, and the saturating output register. Other pixels leave no result. The
// whole pipeline advances together, so while a finished point is held by point_stall no new
// pixel is taken. The user must write configuration only while no pixel is in flight; the
// block does not check. Focal length zero saturates x or y toward the sign of the numerator.
module depth_pixel_backprojection_top import dpb_pkg::*; #(
  parameter int SUBSAMPLE_STEP = SUBSAMPLE_STEP_DEF,
  parameter int MAX_DIMENSION  = MAX_DIMENSION_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     pixel_valid,
  output logic                     pixel_stall,
  input  logic [COORD_W-1:0]       pixel_col,
  input  logic [COORD_W-1:0]       pixel_row,
  input  logic [DEPTH_W-1:0]       depth_value,
  input  logic                     depth_missing,
  input  logic [CONF_W-1:0]        confidence,
  output logic                     point_valid,
  input  logic                     point_stall,
  output logic signed [OUT_W-1:0]  point_x,
  output logic signed [OUT_W-1:0]  point_y,
  output logic [DEPTH_W-1:0]       point_z,
  output logic [CONF_W-1:0]        point_confidence,
  input  logic                     cfg_write,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]         cfg_data
);

  logic [CFG_W-1:0] focal_x;
  logic [CFG_W-1:0] focal_y;
  logic [CFG_W-1:0] center_x;
  logic [CFG_W-1:0] center_y;
  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;

  logic             en;
  axis_t            axis_x;
  axis_t            axis_y;
  side_t            front_side;

  logic [NUM_W-1:0] quot_x;
  logic [NUM_W-1:0] quot_y;
  logic             neg_x;
  logic             neg_y;
  logic             nz_x;
  logic             nz_y;

  logic               side_v     [0:NUM_W-1];
  logic [DEPTH_W-1:0] side_depth [0:NUM_W-1];
  logic [CONF_W-1:0]  side_conf  [0:NUM_W-1];

  function automatic logic [OUT_W-1:0] saturate(input logic neg, input logic nz,
                                                input logic [NUM_W-1:0] q);
    logic [NUM_W-1:0] neg_q;
    logic [OUT_W-1:0] res;
    neg_q = ~q + 1'b1;
    if (!nz) begin
      res = '0;
    end else if (!neg) begin
      res = (q > NUM_W'(OUT_POS_MAX)) ? OUT_POS_MAX : q[OUT_W-1:0];
    end else begin
      res = (q > NUM_W'(OUT_NEG_MIN)) ? OUT_NEG_MIN : neg_q[OUT_W-1:0];
    end
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x      <= FOCAL_X_RST;
      focal_y      <= FOCAL_Y_RST;
      center_x     <= CENTER_X_RST;
      center_y     <= CENTER_Y_RST;
      image_width  <= IMAGE_WIDTH_RST;
      image_height <= IMAGE_HEIGHT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FOCAL_X:      focal_x      <= cfg_data;
        REG_FOCAL_Y:      focal_y      <= cfg_data;
        REG_CENTER_X:     center_x     <= cfg_data;
        REG_CENTER_Y:     center_y     <= cfg_data;
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // a held result freezes every stage
  assign en          = !(point_valid && point_stall);
  assign pixel_stall = !en;

  dpb_front #(
    .SUBSAMPLE_STEP (SUBSAMPLE_STEP),
    .MAX_DIMENSION  (MAX_DIMENSION)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .pixel_valid   (pixel_valid),
    .pixel_col     (pixel_col),
    .pixel_row     (pixel_row),
    .depth_value   (depth_value),
    .depth_missing (depth_missing),
    .confidence    (confidence),
    .center_x      (center_x),
    .center_y      (center_y),
    .image_width   (image_width),
    .image_height  (image_height),
    .axis_x        (axis_x),
    .axis_y        (axis_y),
    .side          (front_side)
  );

  dpb_div u_div_x (
    .clk      (clk),
    .en       (en),
    .den      (focal_x),
    .num_in   (axis_x),
    .quotient (quot_x),
    .neg      (neg_x),
    .nz       (nz_x)
  );

  dpb_div u_div_y (
    .clk      (clk),
    .en       (en),
    .den      (focal_y),
    .num_in   (axis_y),
    .quotient (quot_y),
    .neg      (neg_y),
    .nz       (nz_y)
  );

  // valid, depth and confidence ride alongside the divider stages
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NUM_W; s++) begin
        side_v[s] <= 1'b0;
      end
    end else if (en) begin
      side_v[0] <= front_side.valid;
      for (int s = 1; s < NUM_W; s++) begin
        side_v[s] <= side_v[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_depth[0] <= front_side.depth;
      side_conf[0]  <= front_side.conf;
      for (int s = 1; s < NUM_W; s++) begin
        side_depth[s] <= side_depth[s-1];
        side_conf[s]  <= side_conf[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      point_valid <= 1'b0;
    end else if (en) begin
      point_valid <= side_v[NUM_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      point_x          <= saturate(neg_x, nz_x, quot_x);
      point_y          <= saturate(neg_y, nz_y, quot_y);
      point_z          <= side_depth[NUM_W-1];
      point_confidence <= side_conf[NUM_W-1];
    end
  end

endmodule

/* hw/rtl/dpb_front.sv */
// Front stages: pixel filtering, offset from principal point and depth multiply.
module dpb_front import dpb_pkg::*; #(
  parameter int SUBSAMPLE_STEP = SUBSAMPLE_STEP_DEF,
  parameter int MAX_DIMENSION  = MAX_DIMENSION_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               pixel_valid,
  input  logic [COORD_W-1:0] pixel_col,
  input  logic [COORD_W-1:0] pixel_row,
  input  logic [DEPTH_W-1:0] depth_value,
  input  logic               depth_missing,
  input  logic [CONF_W-1:0]  confidence,
  input  logic [CFG_W-1:0]   center_x,
  input  logic [CFG_W-1:0]   center_y,
  input  logic [DIM_W-1:0]   image_width,
  input  logic [DIM_W-1:0]   image_height,
  output axis_t              axis_x,
  output axis_t              axis_y,
  output side_t              side
);

  // floor(n / STEP) as (n * M) >> SHIFT, exact for every 12-bit n
  localparam int RECIP_SHIFT = COORD_W + $clog2(SUBSAMPLE_STEP);
  localparam int RPROD_W     = COORD_W + RECIP_SHIFT + 1;
  localparam logic [RPROD_W-1:0] RECIP_M =
    RPROD_W'(((1 << RECIP_SHIFT) + SUBSAMPLE_STEP - 1) / SUBSAMPLE_STEP);
  localparam int CHK_W = COORD_W + $clog2(SUBSAMPLE_STEP) + 1;
  localparam logic [CHK_W-1:0] STEP_C    = CHK_W'(SUBSAMPLE_STEP);
  localparam logic [DIM_W-1:0] MAX_DIM_C = DIM_W'(MAX_DIMENSION);

  logic [DIM_W-1:0]   width_eff;
  logic [DIM_W-1:0]   height_eff;
  logic               pixel_ok;
  logic [RPROD_W-1:0] col_prod;
  logic [RPROD_W-1:0] row_prod;

  logic               s1_valid;
  logic [COORD_W-1:0] s1_col;
  logic [COORD_W-1:0] s1_row;
  logic [COORD_W-1:0] s1_qcol;
  logic [COORD_W-1:0] s1_qrow;
  logic [DIFF_W-1:0]  s1_dx;
  logic [DIFF_W-1:0]  s1_dy;
  logic [DEPTH_W-1:0] s1_depth;
  logic [CONF_W-1:0]  s1_conf;

  logic               on_grid;
  logic               neg_x;
  logic               neg_y;
  logic [DIFF_W-1:0]  abs_x;
  logic [DIFF_W-1:0]  abs_y;

  logic               s2_valid;
  logic               s2_neg_x;
  logic               s2_neg_y;
  logic [NUM_W-1:0]   s2_mag_x;
  logic [NUM_W-1:0]   s2_mag_y;
  logic [DEPTH_W-1:0] s2_depth;
  logic [CONF_W-1:0]  s2_conf;

  always_comb begin
    width_eff  = (image_width > MAX_DIM_C) ? MAX_DIM_C : image_width;
    height_eff = (image_height > MAX_DIM_C) ? MAX_DIM_C : image_height;
    pixel_ok   = !depth_missing && (depth_value != '0) && (depth_value <= DEPTH_LIMIT) &&
                 ({1'b0, pixel_col} < width_eff) && ({1'b0, pixel_row} < height_eff);
    col_prod   = RPROD_W'(pixel_col) * RECIP_M;
    row_prod   = RPROD_W'(pixel_row) * RECIP_M;
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= pixel_valid && pixel_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_col   <= pixel_col;
      s1_row   <= pixel_row;
      s1_qcol  <= col_prod[RECIP_SHIFT +: COORD_W];
      s1_qrow  <= row_prod[RECIP_SHIFT +: COORD_W];
      s1_dx    <= DIFF_W'({pixel_col, 4'b0000}) - DIFF_W'(center_x);
      s1_dy    <= DIFF_W'({pixel_row, 4'b0000}) - DIFF_W'(center_y);
      s1_depth <= depth_value;
      s1_conf  <= confidence;
    end
  end

  always_comb begin
    on_grid = (CHK_W'(s1_qcol) * STEP_C == CHK_W'(s1_col)) &&
              (CHK_W'(s1_qrow) * STEP_C == CHK_W'(s1_row));
    neg_x   = s1_dx[DIFF_W-1];
    neg_y   = s1_dy[DIFF_W-1];
    abs_x   = neg_x ? (~s1_dx + 1'b1) : s1_dx;
    abs_y   = neg_y ? (~s1_dy + 1'b1) : s1_dy;
  end

  // stage 2
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid && on_grid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_neg_x <= neg_x;
      s2_neg_y <= neg_y;
      s2_mag_x <= NUM_W'(abs_x[MAG_W-1:0]) * NUM_W'(s1_depth);
      s2_mag_y <= NUM_W'(abs_y[MAG_W-1:0]) * NUM_W'(s1_depth);
      s2_depth <= s1_depth;
      s2_conf  <= s1_conf;
    end
  end

  assign axis_x = '{neg: s2_neg_x, mag: s2_mag_x};
  assign axis_y = '{neg: s2_neg_y, mag: s2_mag_y};
  assign side   = '{valid: s2_valid, depth: s2_depth, conf: s2_conf};

endmodule

/* hw/rtl/dpb_div.sv */
// Pipelined restoring divider: one quotient bit per stage, magnitude over focal length.
module dpb_div import dpb_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [CFG_W-1:0] den,
  input  axis_t            num_in,
  output logic [NUM_W-1:0] quotient,
  output logic             neg,
  output logic             nz
);

  logic [CFG_W-1:0] rem_q     [0:NUM_W-2];
  logic [NUM_W-1:0] work_q    [0:NUM_W-1];
  logic             neg_q     [0:NUM_W-1];
  logic             nz_q      [0:NUM_W-1];

  logic [CFG_W-1:0] r_in      [0:NUM_W-1];
  logic [NUM_W-1:0] w_in      [0:NUM_W-1];
  logic             n_in      [0:NUM_W-1];
  logic             z_in      [0:NUM_W-1];
  logic [CFG_W:0]   trial     [0:NUM_W-1];
  logic             ge        [0:NUM_W-1];
  logic [CFG_W-1:0] rem_next  [0:NUM_W-2];
  logic [NUM_W-1:0] work_next [0:NUM_W-1];

  // work holds the unconsumed dividend bits on top and quotient bits below
  always_comb begin
    r_in[0] = '0;
    w_in[0] = num_in.mag;
    n_in[0] = num_in.neg;
    z_in[0] = |num_in.mag;
    for (int s = 1; s < NUM_W; s++) begin
      r_in[s] = rem_q[s-1];
      w_in[s] = work_q[s-1];
      n_in[s] = neg_q[s-1];
      z_in[s] = nz_q[s-1];
    end
    for (int s = 0; s < NUM_W; s++) begin
      trial[s]     = {r_in[s], w_in[s][NUM_W-1]};
      ge[s]        = trial[s] >= {1'b0, den};
      work_next[s] = {w_in[s][NUM_W-2:0], ge[s]};
    end
    // a zero divisor sets every quotient bit, which later saturates
    for (int s = 0; s < NUM_W - 1; s++) begin
      rem_next[s] = ge[s] ? CFG_W'(trial[s] - {1'b0, den}) : CFG_W'(trial[s]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NUM_W; s++) begin
        work_q[s] <= work_next[s];
        neg_q[s]  <= n_in[s];
        nz_q[s]   <= z_in[s];
      end
      for (int s = 0; s < NUM_W - 1; s++) begin
        rem_q[s] <= rem_next[s];
      end
    end
  end

  assign quotient = work_q[NUM_W-1];
  assign neg      = neg_q[NUM_W-1];
  assign nz       = nz_q[NUM_W-1];

endmodule

/* hw/rtl/dpb_checker.sv */
// Port-level checks for the depth back-projection top level, bound to it.
module dpb_checker import dpb_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    pixel_stall,
  input logic                    point_valid,
  input logic                    point_stall,
  input logic signed [OUT_W-1:0] point_x,
  input logic signed [OUT_W-1:0] point_y,
  input logic [DEPTH_W-1:0]      point_z,
  input logic [CONF_W-1:0]       point_confidence
);

  // a stalled point keeps its transaction intact
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    point_valid && point_stall |=> point_valid && $stable(point_x) && $stable(point_y) &&
    $stable(point_z) && $stable(point_confidence))
    else $error("stalled point changed");

  // only depths in range are ever projected
  a_z_range: assert property (@(posedge clk) disable iff (rst)
    point_valid |-> (point_z != '0) && (point_z <= DEPTH_LIMIT))
    else $error("point depth out of range");

  // input is held off exactly while a finished point waits
  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    pixel_stall == (point_valid && point_stall))
    else $error("pixel stall does not follow output backpressure");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !point_valid)
    else $error("point valid after reset");

endmodule

bind depth_pixel_backprojection_top dpb_checker u_dpb_checker (.*);
